### hdl/scfk_pkg.sv
// ----------------------------------------------------------------------------
// Serial-chain forward kinematics: shared types and constants
// Status codes, operation codes, CORDIC arctangent table and sizes.
// ----------------------------------------------------------------------------
package scfk_pkg;

	localparam int MAX_LINKS_DEF  = 16;
	localparam int ANGLE_BITS_DEF = 16;

	localparam int ID_W    = 4;
	localparam int NUM_IDS = 16;
	localparam int LEN_W   = 16;
	localparam int POS_W   = 24;
	localparam int CFG_W   = 16;
	localparam int STAT_W  = 3;
	localparam int OP_W    = 2;
	localparam int TRIG_W  = 20;

	localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
	localparam logic [OP_W-1:0] OP_SET   = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
	localparam logic [STAT_W-1:0] ST_DUP     = 3'd1;
	localparam logic [STAT_W-1:0] ST_MISSING = 3'd2;
	localparam logic [STAT_W-1:0] ST_BROKEN  = 3'd3;
	localparam logic [STAT_W-1:0] ST_COLLIDE = 3'd4;

	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_INV = 20'sd39796;

	// Arctangent of 2^-i in units of 1/65536 turn.
	function automatic logic signed [TRIG_W-1:0] atan_lut(input logic [3:0] i);
		logic signed [TRIG_W-1:0] v;
		case (i)
			4'd0:  v = 20'sd8192;
			4'd1:  v = 20'sd4836;
			4'd2:  v = 20'sd2555;
			4'd3:  v = 20'sd1297;
			4'd4:  v = 20'sd651;
			4'd5:  v = 20'sd326;
			4'd6:  v = 20'sd163;
			4'd7:  v = 20'sd81;
			4'd8:  v = 20'sd41;
			4'd9:  v = 20'sd20;
			4'd10: v = 20'sd10;
			4'd11: v = 20'sd5;
			4'd12: v = 20'sd3;
			4'd13: v = 20'sd1;
			4'd14: v = 20'sd1;
			default: v = 20'sd0;
		endcase
		return v;
	endfunction

endpackage

### hdl/serial_chain_forward_kinematics_top.sv
// ----------------------------------------------------------------------------
// Serial-chain forward kinematics
// Link table, chain walk, CORDIC trig and joint collision check.
// ----------------------------------------------------------------------------
// An add item writes its link table entry; a set item reads the entry and
// writes it back with the new angles. A query first walks from the link to
// the base, one table read per link, then for each link of the chain reads
// its id from the path memory and its entry from the link table, runs two
// 16-step CORDIC rotations (pitch, then yaw) on one shared rotator, three
// multiply steps for the position increment and one pass over all earlier
// joints in the joint memory, reading, differencing, squaring and comparing
// each. The link table and the joint memory are synchronous RAMs with a
// registered read; the valid bits of the link table are flip-flops cleared by
// reset. One item is handled at a time; the result waits in an output
// register and the input stalls until it is taken.
module serial_chain_forward_kinematics_top #(
	parameter int MAX_LINKS  = scfk_pkg::MAX_LINKS_DEF,
	parameter int ANGLE_BITS = scfk_pkg::ANGLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [scfk_pkg::OP_W-1:0]           operation,
	input  logic [scfk_pkg::ID_W-1:0]           link_id,
	input  logic [scfk_pkg::ID_W-1:0]           parent_id,
	input  logic [scfk_pkg::LEN_W-1:0]          link_length,
	input  logic [ANGLE_BITS-1:0]               pitch,
	input  logic [ANGLE_BITS-1:0]               yaw,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [scfk_pkg::CFG_W-1:0]          cfg_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [scfk_pkg::STAT_W-1:0]         status,
	output logic signed [scfk_pkg::POS_W-1:0]   pos_x,
	output logic signed [scfk_pkg::POS_W-1:0]   pos_y,
	output logic signed [scfk_pkg::POS_W-1:0]   pos_z,
	output logic [scfk_pkg::ID_W-1:0]           offending_link
);

	localparam int ID_W   = scfk_pkg::ID_W;
	localparam int POS_W  = scfk_pkg::POS_W;
	localparam int CFG_W  = scfk_pkg::CFG_W;
	localparam int TW     = scfk_pkg::TRIG_W;
	localparam int NW     = $clog2(MAX_LINKS + 1);
	localparam int KW     = $clog2(MAX_LINKS);
	localparam int SH_DN  = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
	localparam int SH_UP  = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
	localparam int ENT_W  = ID_W + scfk_pkg::LEN_W + 2 * ANGLE_BITS;
	localparam int JNT_W  = 3 * POS_W;

	// State codes
	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_SETRD  = 5'd1;
	localparam logic [4:0] S_SETWR  = 5'd2;
	localparam logic [4:0] S_WALKRD = 5'd3;
	localparam logic [4:0] S_WALK   = 5'd4;
	localparam logic [4:0] S_LNKRD  = 5'd5;
	localparam logic [4:0] S_LNK    = 5'd6;
	localparam logic [4:0] S_CINIT  = 5'd7;
	localparam logic [4:0] S_CITER  = 5'd8;
	localparam logic [4:0] S_MUL1   = 5'd9;
	localparam logic [4:0] S_MUL2   = 5'd10;
	localparam logic [4:0] S_MUL3   = 5'd11;
	localparam logic [4:0] S_JRD    = 5'd12;
	localparam logic [4:0] S_JSQ    = 5'd13;
	localparam logic [4:0] S_JSUM   = 5'd14;
	localparam logic [4:0] S_NEXT   = 5'd15;
	localparam logic [4:0] S_OUT    = 5'd16;
	localparam logic [4:0] S_JSQ2   = 5'd17;
	localparam logic [4:0] S_JCMP   = 5'd18;
	localparam logic [4:0] S_PATHRD = 5'd19;

	logic [4:0] state_q;

	// Memories
	logic [ENT_W-1:0] ent_mem [scfk_pkg::NUM_IDS];
	logic [ID_W-1:0]  path_mem [MAX_LINKS];
	logic [JNT_W-1:0] jnt_mem [MAX_LINKS];
	logic [scfk_pkg::NUM_IDS-1:0] valid_q;

	logic             ent_we;
	logic [ID_W-1:0]  ent_waddr, ent_raddr;
	logic [ENT_W-1:0] ent_wdata, ent_rdata;
	logic             path_we;
	logic [KW-1:0]    path_waddr, path_raddr;
	logic [ID_W-1:0]  path_wdata, path_rdata;
	logic             jnt_we;
	logic [KW-1:0]    jnt_waddr, jnt_raddr;
	logic [JNT_W-1:0] jnt_rdata;

	// Item registers
	logic [ID_W-1:0]            id_q, par_q, cur_q, last_q, lid_q;
	logic [scfk_pkg::LEN_W-1:0] len_q;
	logic [ANGLE_BITS-1:0]      pit_q, yaw_q, ap_q, ay_q;
	logic [CFG_W-1:0]           min_sep_q;
	logic [NW-1:0]              n_q;
	logic [KW-1:0]              k_q, j_q;
	logic signed [POS_W-1:0]    x_q, y_q, z_q;
	logic [scfk_pkg::LEN_W-1:0] r_q;

	// CORDIC
	logic                   yaw_pass_q;
	logic [3:0]             it_q;
	logic [1:0]             quad_q;
	logic signed [TW-1:0]   cx_q, cy_q, cz_q;
	logic signed [TW-1:0]   cp_q, sp_q, cyw_q, syw_q;
	logic signed [TW-1:0]   cos_r, sin_r;
	logic [15:0]            ang16;
	logic [15:0]            qa;
	logic [1:0]             quad;
	logic [15:0]            zrem;

	// Product path
	logic signed [40:0]     rs_q;
	logic signed [63:0]     px_q, py_q;
	logic signed [40:0]     pz_q;
	logic signed [POS_W+1:0] sx, sy, sz;

	// Distance check
	logic signed [POS_W:0]  ex_q, ey_q, ez_q;
	logic [2*POS_W+1:0]     qx_q, qy_q, qz_q;
	logic [2*POS_W+3:0]     dist2;
	logic [2*CFG_W-1:0]     sep2;

	logic [scfk_pkg::STAT_W-1:0] st_q;
	logic [ID_W-1:0]             off_q;
	logic                        out_v_q;

	function automatic logic signed [POS_W+1:0] rnd_shr64(input logic signed [63:0] v,
	                                                        input int n);
		logic signed [63:0] t;
		t = (v + (64'sd1 <<< (n - 1))) >>> n;
		return t[POS_W+1:0];
	endfunction

	function automatic logic signed [POS_W-1:0] sat(input logic signed [POS_W+1:0] v);
		logic signed [POS_W+1:0] hi, lo;
		hi = (POS_W + 2)'(2 ** (POS_W - 1) - 1);
		lo = -hi - 1;
		if (v > hi) return hi[POS_W-1:0];
		if (v < lo) return lo[POS_W-1:0];
		return v[POS_W-1:0];
	endfunction

	// Final CORDIC step for the pitch pass, folded into the quadrant rotation.
	function automatic logic signed [TW-1:0] cos_r_next(
		input logic signed [TW-1:0] x, input logic signed [TW-1:0] y,
		input logic signed [TW-1:0] z, input logic [3:0] i,
		input logic [1:0] q, input logic want_cos);
		logic signed [TW-1:0] nx, ny, c, s;
		if (z >= 0) begin nx = x - (y >>> i); ny = y + (x >>> i); end
		else begin nx = x + (y >>> i); ny = y - (x >>> i); end
		case (q)
			2'd0: begin c = nx;  s = ny;  end
			2'd1: begin c = -ny; s = nx;  end
			2'd2: begin c = -nx; s = -ny; end
			default: begin c = ny; s = -nx; end
		endcase
		return want_cos ? c : s;
	endfunction

	assign cfg_ready = (state_q == S_IDLE) && !out_v_q;
	assign in_stall  = (state_q != S_IDLE) || out_v_q;
	assign out_valid = out_v_q;
	assign status    = st_q;
	assign offending_link = off_q;

	// Synchronous memories
	always_ff @(posedge clk) begin
		if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
		ent_rdata <= ent_mem[ent_raddr];
		if (path_we) path_mem[path_waddr] <= path_wdata;
		path_rdata <= path_mem[path_raddr];
		if (jnt_we) jnt_mem[jnt_waddr] <= {x_q, y_q, z_q};
		jnt_rdata <= jnt_mem[jnt_raddr];
	end

	// Angle of the current CORDIC pass scaled to 16 bits, quadrant reduction.
	always_comb begin
		logic [ANGLE_BITS-1:0] a;
		a = yaw_pass_q ? ay_q : ap_q;
		ang16 = 16'(({16'd0, a} >> SH_DN) << SH_UP);
		qa    = ang16 + 16'd8192;
		quad  = qa[15:14];
		zrem  = ang16 - {quad, 14'd0};
	end

	// Rotate CORDIC result back into its quadrant.
	always_comb begin
		unique case (quad_q)
			2'd0: begin cos_r = cx_q;  sin_r = cy_q;  end
			2'd1: begin cos_r = -cy_q; sin_r = cx_q;  end
			2'd2: begin cos_r = -cx_q; sin_r = -cy_q; end
			default: begin cos_r = cy_q; sin_r = -cx_q; end
		endcase
	end

	assign sx = (POS_W + 2)'(x_q) + rnd_shr64(px_q, 32);
	assign sy = (POS_W + 2)'(y_q) + rnd_shr64(py_q, 32);
	assign sz = (POS_W + 2)'(z_q) + rnd_shr64(64'(pz_q), 16);
	assign dist2 = (2 * POS_W + 4)'(qx_q) + (2 * POS_W + 4)'(qy_q) + (2 * POS_W + 4)'(qz_q);
	assign sep2 = (2 * CFG_W)'(min_sep_q) * (2 * CFG_W)'(min_sep_q);

	// Memory addressing and write enables
	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = id_q;
		ent_wdata = {par_q, len_q, pit_q, yaw_q};
		ent_raddr = cur_q;
		path_we   = 1'b0;
		path_waddr = n_q[KW-1:0];
		path_wdata = cur_q;
		path_raddr = KW'(n_q - NW'(1) - NW'(k_q));
		jnt_we    = 1'b0;
		jnt_waddr = k_q;
		jnt_raddr = j_q;
		unique case (state_q)
			S_SETRD: ent_raddr = id_q;
			S_SETWR: begin
				ent_we = 1'b1;
				ent_wdata = {ent_rdata[ENT_W-1 -: ID_W + scfk_pkg::LEN_W], pit_q, yaw_q};
			end
			S_IDLE: ent_we = in_valid && !in_stall && operation == scfk_pkg::OP_ADD &&
			                 link_id != '0 && !valid_q[link_id];
			S_WALK: path_we = (cur_q != '0) && n_q < NW'(MAX_LINKS) && valid_q[cur_q];
			S_LNKRD: ent_raddr = path_rdata;
			S_JSUM: jnt_we = 1'b0;
			S_NEXT: jnt_we = 1'b1;
			default: ;
		endcase
		if (state_q == S_IDLE) begin
			ent_waddr = link_id;
			ent_wdata = {parent_id, link_length, pitch, yaw};
		end
	end

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			out_v_q   <= 1'b0;
			min_sep_q <= scfk_pkg::CFG_W'(26);
			st_q      <= scfk_pkg::ST_OK;
			off_q     <= '0;
			pos_x     <= '0;
			pos_y     <= '0;
			pos_z     <= '0;
		end else begin
			if (out_v_q && !out_stall) out_v_q <= 1'b0;
			if (cfg_valid && cfg_ready) min_sep_q <= cfg_data;
			unique case (state_q)
				S_IDLE: if (in_valid && !in_stall) begin
					id_q <= link_id; par_q <= parent_id;
					len_q <= link_length; pit_q <= pitch; yaw_q <= yaw;
					cur_q <= link_id; last_q <= link_id;
					n_q <= '0; st_q <= scfk_pkg::ST_OK; off_q <= '0;
					pos_x <= '0; pos_y <= '0; pos_z <= '0;
					state_q <= S_OUT;
					if (operation == scfk_pkg::OP_ADD) begin
						if (link_id == '0 || valid_q[link_id]) st_q <= scfk_pkg::ST_DUP;
						else valid_q[link_id] <= 1'b1;
					end else if (operation == scfk_pkg::OP_SET ||
					             operation == scfk_pkg::OP_QUERY) begin
						if (link_id == '0 || !valid_q[link_id])
							st_q <= scfk_pkg::ST_MISSING;
						else
							state_q <= (operation == scfk_pkg::OP_SET) ? S_SETRD : S_WALKRD;
					end
				end
				S_SETRD: state_q <= S_SETWR;
				S_SETWR: state_q <= S_OUT;
				S_WALKRD: state_q <= S_WALK;
				S_WALK: begin
					if (cur_q == '0) begin
						k_q <= '0; ap_q <= '0; ay_q <= '0;
						x_q <= '0; y_q <= '0; z_q <= '0;
						state_q <= S_PATHRD;
					end else if (n_q >= NW'(MAX_LINKS) || !valid_q[cur_q]) begin
						st_q <= scfk_pkg::ST_BROKEN; off_q <= last_q;
						state_q <= S_OUT;
					end else begin
						n_q <= n_q + NW'(1);
						last_q <= cur_q;
						cur_q <= ent_rdata[ENT_W-1 -: ID_W];
						state_q <= S_WALKRD;
					end
				end
				// Path entry of link k is being read.
				S_PATHRD: state_q <= S_LNKRD;
				S_LNKRD: begin
					lid_q <= path_rdata;
					state_q <= S_LNK;
				end
				S_LNK: begin
					r_q  <= ent_rdata[2*ANGLE_BITS +: scfk_pkg::LEN_W];
					ap_q <= ap_q + ent_rdata[ANGLE_BITS +: ANGLE_BITS];
					ay_q <= ay_q + ent_rdata[0 +: ANGLE_BITS];
					yaw_pass_q <= 1'b0;
					state_q <= S_CINIT;
				end
				S_CINIT: begin
					quad_q <= quad;
					cx_q <= scfk_pkg::CORDIC_GAIN_INV; cy_q <= '0;
					cz_q <= TW'(signed'(zrem));
					it_q <= '0;
					state_q <= S_CITER;
				end
				S_CITER: begin
					if (cz_q >= 0) begin
						cx_q <= cx_q - (cy_q >>> it_q);
						cy_q <= cy_q + (cx_q >>> it_q);
						cz_q <= cz_q - scfk_pkg::atan_lut(it_q);
					end else begin
						cx_q <= cx_q + (cy_q >>> it_q);
						cy_q <= cy_q - (cx_q >>> it_q);
						cz_q <= cz_q + scfk_pkg::atan_lut(it_q);
					end
					it_q <= it_q + 4'd1;
					if (it_q == 4'd15) state_q <= yaw_pass_q ? S_MUL1 : S_CINIT;
					if (it_q == 4'd15 && !yaw_pass_q) begin
						yaw_pass_q <= 1'b1;
						cp_q <= cos_r_next(cx_q, cy_q, cz_q, it_q, quad_q, 1'b1);
						sp_q <= cos_r_next(cx_q, cy_q, cz_q, it_q, quad_q, 1'b0);
					end
				end
				S_MUL1: begin
					cyw_q <= cos_r; syw_q <= sin_r;
					rs_q <= 41'(signed'({1'b0, r_q})) * 41'(sp_q);
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					px_q <= 64'(rs_q) * 64'(cyw_q);
					pz_q <= 41'(signed'({1'b0, r_q})) * 41'(cp_q);
					state_q <= S_MUL3;
				end
				S_MUL3: begin
					py_q <= 64'(rs_q) * 64'(syw_q);
					state_q <= S_JSUM;
				end
				S_JSUM: begin
					x_q <= sat(sx); y_q <= sat(sy); z_q <= sat(sz);
					j_q <= '0;
					state_q <= S_JRD;
				end
				S_JRD: begin
					if (j_q == k_q) state_q <= S_NEXT;
					else state_q <= S_JSQ;
				end
				S_JSQ: begin
					ex_q <= (POS_W + 1)'(x_q) - (POS_W + 1)'(signed'(jnt_rdata[2*POS_W +: POS_W]));
					ey_q <= (POS_W + 1)'(y_q) - (POS_W + 1)'(signed'(jnt_rdata[POS_W +: POS_W]));
					ez_q <= (POS_W + 1)'(z_q) - (POS_W + 1)'(signed'(jnt_rdata[0 +: POS_W]));
					state_q <= S_JSQ2;
				end
				S_JSQ2: begin
					qx_q <= unsigned'((2 * POS_W + 2)'(ex_q) * (2 * POS_W + 2)'(ex_q));
					qy_q <= unsigned'((2 * POS_W + 2)'(ey_q) * (2 * POS_W + 2)'(ey_q));
					qz_q <= unsigned'((2 * POS_W + 2)'(ez_q) * (2 * POS_W + 2)'(ez_q));
					state_q <= S_JCMP;
				end
				S_JCMP: begin
					if (dist2 < (2 * POS_W + 4)'(sep2)) begin
						st_q <= scfk_pkg::ST_COLLIDE; off_q <= lid_q;
						state_q <= S_OUT;
					end else begin
						j_q <= j_q + KW'(1);
						state_q <= S_JRD;
					end
				end
				S_NEXT: begin
					if (NW'(k_q) + NW'(1) == n_q) begin
						pos_x <= x_q; pos_y <= y_q; pos_z <= z_q;
						state_q <= S_OUT;
					end else begin
						k_q <= k_q + KW'(1);
						state_q <= S_PATHRD;
					end
				end
				S_OUT: begin
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("input taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_stall) |=> (out_v_q && $stable(st_q))) else $error("result lost");
	a_ok_zero_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && st_q == scfk_pkg::ST_OK) |-> (off_q == '0)) else $error("offender on ok");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (n_q <= NW'(MAX_LINKS))) else $error("walk overrun");
`endif

endmodule

### sim/tb_serial_chain_forward_kinematics_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the serial-chain forward kinematics block
// Drives add, set-angle, query and unused-operation items with random bursts
// and gaps, stalls the result side on its own pattern, predicts every result
// from a local copy of the link table and checks each result field by field.
// ----------------------------------------------------------------------------
module tb_serial_chain_forward_kinematics_top;

	localparam int OP_W          = scfk_pkg::OP_W;
	localparam int ID_W          = scfk_pkg::ID_W;
	localparam int LEN_W         = scfk_pkg::LEN_W;
	localparam int POS_W         = scfk_pkg::POS_W;
	localparam int CFG_W         = scfk_pkg::CFG_W;
	localparam int STAT_W        = scfk_pkg::STAT_W;
	localparam int NUM_IDS       = scfk_pkg::NUM_IDS;
	localparam int MAX_LINKS_DEF = scfk_pkg::MAX_LINKS_DEF;

	localparam logic [OP_W-1:0] OP_ADD   = scfk_pkg::OP_ADD;
	localparam logic [OP_W-1:0] OP_SET   = scfk_pkg::OP_SET;
	localparam logic [OP_W-1:0] OP_QUERY = scfk_pkg::OP_QUERY;

	localparam logic [STAT_W-1:0] ST_OK      = scfk_pkg::ST_OK;
	localparam logic [STAT_W-1:0] ST_DUP     = scfk_pkg::ST_DUP;
	localparam logic [STAT_W-1:0] ST_MISSING = scfk_pkg::ST_MISSING;
	localparam logic [STAT_W-1:0] ST_BROKEN  = scfk_pkg::ST_BROKEN;
	localparam logic [STAT_W-1:0] ST_COLLIDE = scfk_pkg::ST_COLLIDE;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int HOLD_AT_ITEM = 300;
	localparam int HOLD_CYCLES = 3000;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [ID_W-1:0]  id;
		logic [ID_W-1:0]  par;
		logic [LEN_W-1:0] len;
		logic [15:0]      pit;
		logic [15:0]      yw;
	} link_item_t;

	typedef struct packed {
		logic [STAT_W-1:0]       st;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
		logic [ID_W-1:0]         offend;
	} pose_result_t;

	logic clk;
	logic arst_n;
	logic in_valid, in_stall;
	logic [OP_W-1:0] operation;
	logic [ID_W-1:0] link_id, parent_id;
	logic [LEN_W-1:0] link_length;
	logic [15:0] pitch, yaw;
	logic cfg_valid, cfg_ready;
	logic [CFG_W-1:0] cfg_data;
	logic out_valid, out_stall;
	logic [STAT_W-1:0] status;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic [ID_W-1:0] offending_link;

	link_item_t pending_items[$];
	pose_result_t expected_poses[$];
	int error_count = 0;
	int accepted_count = 0;

	// Local copy of the link table and the separation register.
	bit link_present[NUM_IDS];
	logic [ID_W-1:0] link_parent[NUM_IDS];
	logic [LEN_W-1:0] link_len[NUM_IDS];
	logic [15:0] link_pitch[NUM_IDS];
	logic [15:0] link_yaw[NUM_IDS];
	logic [CFG_W-1:0] min_sep;

	longint arctan_steps[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
		41, 20, 10, 5, 3, 1, 1, 0};

	serial_chain_forward_kinematics_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .link_id(link_id), .parent_id(parent_id),
		.link_length(link_length), .pitch(pitch), .yaw(yaw),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.offending_link(offending_link)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Rounded shift to nearest, ties toward plus infinity.
	function automatic longint round_shift(input longint v, input int n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clamp24(input longint v);
		if (v > 64'sd8388607) return 64'sd8388607;
		if (v < -64'sd8388608) return -64'sd8388608;
		return v;
	endfunction

	// CORDIC sine and cosine of a 16-bit angle, scale 65536.
	task automatic trig16(input logic [15:0] a, output longint c, output longint s);
		logic [1:0] quad;
		longint z, x, y, nx, ny;
		quad = 2'((({16'd0, a} + 32'd8192) >> 14) & 32'd3);
		z = longint'(16'(a - 16'(quad) * 16'd16384));
		if (z >= 32768) z -= 65536;
		x = 39796;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= arctan_steps[i];
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += arctan_steps[i];
			end
			x = nx;
			y = ny;
		end
		case (quad)
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	// Applies one item to the local table and works out its result.
	task automatic apply_link_item(input link_item_t it, output pose_result_t r);
		logic [ID_W-1:0] chain[MAX_LINKS_DEF];
		longint jx[MAX_LINKS_DEF], jy[MAX_LINKS_DEF], jz[MAX_LINKS_DEF];
		longint x, y, z, cp, sp, cy, sy, rs, ex, ey, ez, m2;
		logic [15:0] ap, ay;
		logic [ID_W-1:0] cur, last, lid;
		int n;
		r = '0;
		case (it.op)
			OP_ADD: begin
				if (it.id == 0 || link_present[it.id]) r.st = ST_DUP;
				else begin
					link_present[it.id] = 1'b1;
					link_parent[it.id] = it.par;
					link_len[it.id] = it.len;
					link_pitch[it.id] = it.pit;
					link_yaw[it.id] = it.yw;
				end
			end
			OP_SET: begin
				if (it.id == 0 || !link_present[it.id]) r.st = ST_MISSING;
				else begin
					link_pitch[it.id] = it.pit;
					link_yaw[it.id] = it.yw;
				end
			end
			OP_QUERY: begin
				if (it.id == 0 || !link_present[it.id]) r.st = ST_MISSING;
				else begin
					// Walk from the link toward the base.
					n = 0;
					cur = it.id;
					last = it.id;
					while (cur != 0) begin
						if (n >= MAX_LINKS_DEF || !link_present[cur]) begin
							r.st = ST_BROKEN;
							r.offend = last;
							break;
						end
						chain[n] = cur;
						n++;
						last = cur;
						cur = link_parent[cur];
					end
					// Go back out from the base, summing angles and positions.
					if (r.st == ST_OK) begin
						ap = 0; ay = 0; x = 0; y = 0; z = 0;
						m2 = longint'(min_sep) * longint'(min_sep);
						for (int k = 0; k < n && r.st == ST_OK; k++) begin
							lid = chain[n - 1 - k];
							ap = ap + link_pitch[lid];
							ay = ay + link_yaw[lid];
							trig16(ap, cp, sp);
							trig16(ay, cy, sy);
							rs = longint'(link_len[lid]) * sp;
							x = clamp24(x + round_shift(rs * cy, 32));
							y = clamp24(y + round_shift(rs * sy, 32));
							z = clamp24(z + round_shift(longint'(link_len[lid]) * cp, 16));
							jx[k] = x; jy[k] = y; jz[k] = z;
							for (int j = 0; j < k; j++) begin
								ex = x - jx[j]; ey = y - jy[j]; ez = z - jz[j];
								if (ex * ex + ey * ey + ez * ez < m2) begin
									r.st = ST_COLLIDE;
									r.offend = lid;
									break;
								end
							end
						end
						if (r.st == ST_OK) begin
							r.x = x[POS_W-1:0];
							r.y = y[POS_W-1:0];
							r.z = z[POS_W-1:0];
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input longint got,
		input longint want);
		$display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
		error_count++;
	endtask

	// Sender: bursts of random length with random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		link_item_t it;
		pose_result_t r;
		logic next_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= '0; link_id <= '0; parent_id <= '0;
			link_length <= '0; pitch <= '0; yaw <= '0;
		end else begin
			next_valid = in_valid;
			if (in_valid && !in_stall) begin
				it = '{operation, link_id, parent_id, link_length, pitch, yaw};
				apply_link_item(it, r);
				expected_poses = {expected_poses, r};
				accepted_count++;
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (gap_left > 0) gap_left--;
				else if (pending_items.size() > 0) begin
					it = pending_items.pop_front();
					operation <= it.op; link_id <= it.id; parent_id <= it.par;
					link_length <= it.len; pitch <= it.pit; yaw <= it.yw;
					next_valid = 1'b1;
					if (burst_left > 0) burst_left--;
					else begin
						burst_left = $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
					end
				end
			end
			in_valid <= next_valid;
		end
	end

	// One long hold-off on the result side while items keep coming.
	int hold_left = 0;
	bit hold_done = 0;
	always @(posedge clk) begin
		if (!hold_done && accepted_count >= HOLD_AT_ITEM) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) hold_left <= hold_left - 1;
	end

	// Receiver: stalls in random stretches with quiet stretches in between.
	int stall_mode_left = 0;
	bit stall_mode = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_stall <= 1'b0;
		else begin
			if (stall_mode_left == 0) begin
				stall_mode_left = $urandom_range(10, 300);
				stall_mode = $urandom_range(0, 1);
			end else stall_mode_left--;
			out_stall <= (hold_left > 0) || (stall_mode && $urandom_range(0, 2) != 0);
		end
	end

	// Result check against the oldest expectation.
	always @(posedge clk) begin
		pose_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_poses.size() == 0) begin
				report_mismatch("unexpected result status", longint'(status), 0);
			end else begin
				want = expected_poses.pop_front();
				if (status !== want.st)
					report_mismatch("status", longint'(status), longint'(want.st));
				if (pos_x !== want.x)
					report_mismatch("pos_x", longint'(pos_x), longint'(want.x));
				if (pos_y !== want.y)
					report_mismatch("pos_y", longint'(pos_y), longint'(want.y));
				if (pos_z !== want.z)
					report_mismatch("pos_z", longint'(pos_z), longint'(want.z));
				if (offending_link !== want.offend)
					report_mismatch("offending_link", longint'(offending_link),
						longint'(want.offend));
			end
		end
	end

	task automatic push_item(input logic [OP_W-1:0] op, input int id, input int par,
		input int len, input int pit, input int yw);
		link_item_t it;
		it = '{op, ID_W'(id), ID_W'(par), LEN_W'(len), 16'(pit), 16'(yw)};
		pending_items = {pending_items, it};
	endtask

	// Waits until every item has been taken and every result has come back.
	task automatic wait_drained();
		while (pending_items.size() > 0 || in_valid || expected_poses.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_min_sep(input logic [CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		min_sep = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic push_random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			push_item(OP_SET, $urandom_range(1, 15), $urandom_range(0, 15),
				$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
		else if (pick < 85)
			push_item(OP_QUERY, $urandom_range(0, 15), $urandom_range(0, 15),
				$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
		else if (pick < 95)
			push_item(OP_ADD, $urandom_range(0, 15), $urandom_range(0, 15),
				$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
		else
			push_item(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
				$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
	endtask

	initial begin
		logic [CFG_W-1:0] phase_sep[5];
		for (int i = 0; i < NUM_IDS; i++) link_present[i] = 1'b0;
		min_sep = 16'd26;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: base id, unknown operation, missing links,
		// broken chains, a cycle, extreme lengths and a zero-length collision.
		write_min_sep(16'd26);
		push_item(OP_ADD, 0, 0, 100, 0, 0);
		push_item(OP_SET, 0, 0, 0, 100, 100);
		push_item(OP_QUERY, 0, 0, 0, 0, 0);
		push_item(OP_UNUSED, 15, 15, 65535, 65535, 65535);
		push_item(OP_QUERY, 3, 0, 0, 0, 0);
		push_item(OP_SET, 3, 0, 0, 0, 0);
		push_item(OP_ADD, 5, 9, 256, 16384, 0);
		push_item(OP_QUERY, 5, 0, 0, 0, 0);
		push_item(OP_ADD, 9, 5, 256, 0, 16384);
		push_item(OP_QUERY, 9, 0, 0, 0, 0);
		push_item(OP_ADD, 1, 0, 65535, 65535, 65535);
		push_item(OP_QUERY, 1, 0, 0, 0, 0);
		push_item(OP_ADD, 1, 0, 1, 1, 1);
		push_item(OP_ADD, 2, 1, 0, 8192, 0);
		push_item(OP_QUERY, 2, 0, 0, 0, 0);
		push_item(OP_SET, 1, 0, 0, 32768, 49152);
		push_item(OP_ADD, 3, 2, 512, 0, 0);
		push_item(OP_ADD, 4, 3, 65535, 16384, 32768);
		push_item(OP_QUERY, 4, 0, 0, 0, 0);
		push_item(OP_SET, 2, 0, 0, 40000, 12345);
		push_item(OP_QUERY, 4, 0, 0, 0, 0);
		for (int id = 6; id <= 15; id++)
			if (id != 9) push_item(OP_ADD, id, (id == 6) ? 4 : ((id == 10) ? 8 : id - 1),
				$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
		push_item(OP_QUERY, 15, 0, 0, 0, 0);
		wait_drained();

		// Random phases, each under its own separation setting.
		phase_sep = '{16'd0, 16'd65535, 16'd1500, 16'($urandom_range(0, 65535)), 16'd26};
		foreach (phase_sep[p]) begin
			write_min_sep(phase_sep[p]);
			for (int i = 0; i < 200; i++) push_random_item();
			wait_drained();
		end

		repeat (1000) @(posedge clk);
		if (error_count == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule

### serial_chain_forward_kinematics_top.f
hdl/scfk_pkg.sv
hdl/serial_chain_forward_kinematics_top.sv
sim/tb_serial_chain_forward_kinematics_top.sv
